>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the touch mapper modules. They use the
// local clk and rst of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/tr2p_pkg.sv
// ----------------------------------------------------------------------------
// tr2p_pkg
// Types and constants of the touch sample to pixel mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package tr2p_pkg;

  localparam int RAW_BITS    = 12;
  localparam int CORNER_W    = 14;
  localparam int SPAN_W      = 14;
  localparam int PIX_W       = 14;
  localparam int PIX_X_W     = 9;
  localparam int PIX_Y_W     = 8;
  localparam int SUM_W       = 13;
  localparam int TOUCH_FLOOR = 20;
  localparam int MEAN_LIMIT  = 2;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_BURST_LENGTH  = 16;

  typedef enum logic [2:0] {
    REG_C0X, REG_C0Y, REG_C1X, REG_C1Y, REG_C2X, REG_C2Y, REG_C3X, REG_C3Y
  } reg_idx_t;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic               touched;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
  } result_t;

  typedef struct packed {
    logic signed [CORNER_W-1:0] c0x;
    logic signed [CORNER_W-1:0] c0y;
    logic signed [CORNER_W-1:0] c1x;
    logic signed [CORNER_W-1:0] c1y;
    logic signed [CORNER_W-1:0] c2x;
    logic signed [CORNER_W-1:0] c2y;
    logic signed [CORNER_W-1:0] c3x;
    logic signed [CORNER_W-1:0] c3y;
  } corners_t;

  typedef struct packed {
    sample_t smp;
    logic    hit;
  } job_t;

  typedef struct packed {
    logic                    hit;
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
  } map_res_t;

  typedef enum logic [3:0] {
    M_IDLE, M_DIVX, M_DIVY, M_MULM, M_MULX, M_SCLX, M_DIVSX,
    M_MULY, M_SCLY, M_DIVSY, M_DONE
  } map_state_t;

endpackage
`default_nettype wire

>>> sv/tr2p_front.sv
// ----------------------------------------------------------------------------
// tr2p_front
// Takes sample beats and tags each as touched or untouched before queuing.
// ----------------------------------------------------------------------------
`default_nettype none
module tr2p_front import tr2p_pkg::*; (
  input  sample_t  sample,
  input  logic     push,
  output logic     full,
  input  corners_t corners,
  input  logic     q_full,
  output logic     q_push,
  output job_t     job
);

  logic raw_ok;
  logic span_ok;

  assign raw_ok  = (sample.raw_x > RAW_BITS'(TOUCH_FLOOR)) &&
                   (sample.raw_y > RAW_BITS'(TOUCH_FLOOR));
  assign span_ok = (corners.c0x != corners.c1x) && (corners.c0y != corners.c3y);

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign job.smp  = sample;
  assign job.hit  = raw_ok && span_ok;

endmodule
`default_nettype wire

>>> sv/tr2p_fifo.sv
// ----------------------------------------------------------------------------
// tr2p_fifo
// Two-entry queue between the front and the mapper.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tr2p_fifo import tr2p_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  `ASSERT_AT(a_cnt_max, count <= 2'd2, "queue count above depth")
  `ASSERT_AT(a_cnt_up, wr && !rd |=> count == $past(count) + 2'd1, "queue count missed a beat")

endmodule
`default_nettype wire

>>> sv/tr2p_map.sv
// ----------------------------------------------------------------------------
// tr2p_map
// Sequential mapper: raw sample to pixel through a bit-serial divider and
// a bit-serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module tr2p_map import tr2p_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic     clk,
  input  logic     rst,
  input  corners_t corners,
  input  job_t     job,
  input  logic     job_valid,
  output logic     job_pop,
  output map_res_t res,
  output logic     res_valid,
  input  logic     res_ready
);

  localparam int VB   = ((RAW_BITS > 13) ? RAW_BITS : 13) + 1;
  localparam int QB   = VB + 16;
  localparam int MB   = 48;
  localparam int SMAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QSB  = $clog2(SMAX);
  localparam int SCW  = $clog2(SMAX + 1);
  localparam int SPW  = SPAN_W + 16;
  localparam int DDW  = (QB > SPW + SCW) ? QB : SPW + SCW;
  localparam int DSW  = ((SPAN_W + QB) > (SPW + QSB)) ? SPAN_W + QB : SPW + QSB;
  localparam int QW   = QB;
  localparam int AW   = (QB > MB) ? QB : MB;
  localparam int BW   = QB;
  localparam int PW   = AW + BW;
  localparam int NW   = ((QB > SPAN_W + MB) ? QB : SPAN_W + MB) + 2;
  localparam int CNTW = $clog2(QB);
  localparam logic [MB-1:0] M_LIMIT = MB'(1) << (MB - 1);

  function automatic logic [SPAN_W-1:0] span_abs(input logic signed [CORNER_W-1:0] a,
                                                 input logic signed [CORNER_W-1:0] b);
    logic signed [CORNER_W:0] d;
    d = (CORNER_W+1)'(a) - (CORNER_W+1)'(b);
    return d[CORNER_W] ? SPAN_W'(-d) : SPAN_W'(d);
  endfunction

  map_state_t state, state_next;

  logic                    hit;
  logic [VB-1:0]           vxm, vym;
  logic                    vxn, vyn;
  logic [SPAN_W-1:0]       wspan, hspan, dxm, dym;
  logic                    dxn, dyn;
  logic [QB-1:0]           axm;
  logic [MB-1:0]           mm;
  logic                    mn;
  logic signed [NW-1:0]    num;
  logic signed [PIX_W-1:0] px, py;
  logic [DDW-1:0]          rem;
  logic [DSW-1:0]          dsh;
  logic [QW-1:0]           quo;
  logic [PW-1:0]           acc, a_sh;
  logic [BW-1:0]           b_sh;
  logic [CNTW-1:0]         cnt;

  // load-time values
  logic signed [VB:0]     vx_d, vy_d;
  logic [VB-1:0]          vxm_d, vym_d;
  logic [SPAN_W-1:0]      w_abs, h_abs, dxa, dya;
  logic signed [SPAN_W:0] dx_d, dy_d;

  // shared units
  logic           rem_ge;
  logic [DDW-1:0] rem_sub;
  logic [QW-1:0]  quo_next;
  logic [PW-1:0]  acc_next;
  logic [PW-17:0] ph;
  logic [MB-1:0]  m_sat;
  logic           last;

  // numerator and scaling
  logic [VB-1:0]        vm_sel;
  logic                 vn_sel, dn_sel;
  logic [NW-1:0]        v_sh_u;
  logic signed [NW-1:0] v_sh, t_s, num_d, lim;
  logic [SPAN_W-1:0]    span_sel;
  logic [SCW-1:0]       scr_sel;
  logic                 num_pos, in_range;
  logic [DDW-1:0]       scl_prod;
  logic [DSW-1:0]       dsh_scl;

  always_comb begin
    vx_d  = $signed({{(VB+1-RAW_BITS){1'b0}}, job.smp.raw_x}) - (VB+1)'(corners.c0x);
    vy_d  = $signed({{(VB+1-RAW_BITS){1'b0}}, job.smp.raw_y}) - (VB+1)'(corners.c0y);
    vxm_d = vx_d[VB] ? VB'(-vx_d) : VB'(vx_d);
    vym_d = vy_d[VB] ? VB'(-vy_d) : VB'(vy_d);
    w_abs = span_abs(corners.c0x, corners.c1x);
    h_abs = span_abs(corners.c0y, corners.c3y);
    dxa   = span_abs(corners.c2x, corners.c3x);
    dya   = span_abs(corners.c1y, corners.c2y);
    dx_d  = $signed({1'b0, dxa}) - $signed({1'b0, w_abs});
    dy_d  = $signed({1'b0, dya}) - $signed({1'b0, h_abs});
  end

  always_comb begin
    rem_ge   = (DSW'(rem) >= dsh);
    rem_sub  = rem - DDW'(dsh);
    quo_next = {quo[QW-2:0], rem_ge};
    acc_next = acc + (b_sh[0] ? a_sh : '0);
    ph       = acc_next[PW-1:16];
    m_sat    = (ph >= (PW-16)'(M_LIMIT)) ? M_LIMIT : ph[MB-1:0];
    last     = (cnt == '0);
  end

  always_comb begin
    vm_sel   = (state == M_MULY) ? vym : vxm;
    vn_sel   = (state == M_MULY) ? vyn : vxn;
    dn_sel   = (state == M_MULY) ? dyn : dxn;
    v_sh_u   = NW'({vm_sel, 16'b0});
    v_sh     = vn_sel ? -$signed(v_sh_u) : $signed(v_sh_u);
    t_s      = (dn_sel ^ mn) ? -$signed(NW'(acc_next)) : $signed(NW'(acc_next));
    num_d    = v_sh - t_s;
    span_sel = (state == M_SCLY) ? hspan : wspan;
    scr_sel  = (state == M_SCLY) ? SCW'(SCREEN_HEIGHT) : SCW'(SCREEN_WIDTH);
    lim      = $signed(NW'({span_sel, 16'b0}));
    num_pos  = (num > 0);
    in_range = num_pos && (num < lim);
    scl_prod = DDW'(num[SPW-1:0]) * DDW'(scr_sel);
    dsh_scl  = DSW'({span_sel, 16'b0}) << (QSB - 1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      M_IDLE:  if (job_valid) state_next = job.hit ? M_DIVX : M_DONE;
      M_DIVX:  if (last) state_next = M_DIVY;
      M_DIVY:  if (last) state_next = M_MULM;
      M_MULM:  if (last) state_next = M_MULX;
      M_MULX:  if (last) state_next = M_SCLX;
      M_SCLX:  state_next = in_range ? M_DIVSX : M_MULY;
      M_DIVSX: if (last) state_next = M_MULY;
      M_MULY:  if (last) state_next = M_SCLY;
      M_SCLY:  state_next = in_range ? M_DIVSY : M_DONE;
      M_DIVSY: if (last) state_next = M_DONE;
      M_DONE:  if (res_ready) state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = (state == M_IDLE) && job_valid;
    res_valid = (state == M_DONE);
    res.hit   = hit;
    res.px    = px;
    res.py    = py;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= M_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      M_IDLE: if (job_valid) begin
        hit   <= job.hit;
        vxm   <= vxm_d;
        vym   <= vym_d;
        vxn   <= vx_d[VB];
        vyn   <= vy_d[VB];
        wspan <= w_abs;
        hspan <= h_abs;
        dxm   <= dx_d[SPAN_W] ? SPAN_W'(-dx_d) : SPAN_W'(dx_d);
        dym   <= dy_d[SPAN_W] ? SPAN_W'(-dy_d) : SPAN_W'(dy_d);
        dxn   <= dx_d[SPAN_W];
        dyn   <= dy_d[SPAN_W];
        px    <= '1;
        py    <= '1;
        rem   <= DDW'({vxm_d, 16'b0});
        dsh   <= DSW'(w_abs) << (QB - 1);
        quo   <= '0;
        cnt   <= CNTW'(QB - 1);
      end
      M_DIVX: begin
        rem <= rem_ge ? rem_sub : rem;
        dsh <= dsh >> 1;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (last) begin
          axm <= quo_next;
          rem <= DDW'({vym, 16'b0});
          dsh <= DSW'(hspan) << (QB - 1);
          quo <= '0;
          cnt <= CNTW'(QB - 1);
        end
      end
      M_DIVY: begin
        rem <= rem_ge ? rem_sub : rem;
        dsh <= dsh >> 1;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (last) begin
          a_sh <= PW'(axm);
          b_sh <= BW'(quo_next);
          acc  <= '0;
          cnt  <= CNTW'(BW - 1);
        end
      end
      M_MULM: begin
        acc  <= acc_next;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - 1'b1;
        if (last) begin
          mm   <= m_sat;
          mn   <= vxn ^ vyn;
          a_sh <= PW'(m_sat);
          b_sh <= BW'(dxm);
          acc  <= '0;
          cnt  <= CNTW'(SPAN_W - 1);
        end
      end
      M_MULX, M_MULY: begin
        acc  <= acc_next;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - 1'b1;
        if (last) num <= num_d;
      end
      M_SCLX, M_SCLY: begin
        if (in_range) begin
          rem <= scl_prod;
          dsh <= dsh_scl;
          quo <= '0;
          cnt <= CNTW'(QSB - 1);
        end else begin
          if (state == M_SCLX) px <= num_pos ? PIX_W'(SCREEN_WIDTH) : '0;
          else                 py <= num_pos ? PIX_W'(SCREEN_HEIGHT) : '0;
          a_sh <= PW'(mm);
          b_sh <= BW'(dym);
          acc  <= '0;
          cnt  <= CNTW'(SPAN_W - 1);
        end
      end
      M_DIVSX, M_DIVSY: begin
        rem <= rem_ge ? rem_sub : rem;
        dsh <= dsh >> 1;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (last) begin
          if (state == M_DIVSX) px <= $signed(quo_next[PIX_W-1:0]);
          else                  py <= $signed(quo_next[PIX_W-1:0]);
          a_sh <= PW'(mm);
          b_sh <= BW'(dym);
          acc  <= '0;
          cnt  <= CNTW'(SPAN_W - 1);
        end
      end
      M_DONE: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/tr2p_burst.sv
// ----------------------------------------------------------------------------
// tr2p_burst
// Burst stability check and result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tr2p_burst import tr2p_pkg::*; #(
  parameter int BURST_LENGTH = DEF_BURST_LENGTH
) (
  input  logic     clk,
  input  logic     rst,
  input  map_res_t res,
  input  logic     res_valid,
  output logic     res_ready,
  output result_t  result,
  output logic     empty,
  input  logic     pop
);

  localparam int PHW = $clog2(BURST_LENGTH + 1);
  localparam logic [SUM_W-1:0] SUM_LIM = SUM_W'(MEAN_LIMIT * BURST_LENGTH);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  logic [PHW-1:0]          phase;
  logic signed [PIX_W-1:0] refx, refy;
  logic [SUM_W-1:0]        sum_x, sum_y;
  logic                    out_valid;
  result_t                 out;

  logic                    take;
  logic                    last;
  logic signed [PIX_W:0]   dfx, dfy;
  logic [SUM_W-1:0]        adx, ady;
  logic [SUM_W:0]          addx, addy;
  logic [SUM_W-1:0]        sum_x_next, sum_y_next;
  logic                    stable;

  always_comb begin
    res_ready  = !out_valid || pop;
    take       = res_valid && res_ready;
    last       = (phase == PHW'(BURST_LENGTH));
    dfx        = (PIX_W+1)'(res.px) - (PIX_W+1)'(refx);
    dfy        = (PIX_W+1)'(res.py) - (PIX_W+1)'(refy);
    adx        = dfx[PIX_W] ? SUM_W'(-dfx) : SUM_W'(dfx);
    ady        = dfy[PIX_W] ? SUM_W'(-dfy) : SUM_W'(dfy);
    addx       = {1'b0, sum_x} + {1'b0, adx};
    addy       = {1'b0, sum_y} + {1'b0, ady};
    sum_x_next = addx[SUM_W] ? SUM_MAX : addx[SUM_W-1:0];
    sum_y_next = addy[SUM_W] ? SUM_MAX : addy[SUM_W-1:0];
    stable     = (sum_x_next < SUM_LIM) && (sum_y_next < SUM_LIM);
  end

  assign result = out;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (take) begin
        if (phase == '0) begin
          if (!res.hit) out_valid <= 1'b1;
          else          phase     <= PHW'(1);
        end else if (!last) begin
          phase <= phase + 1'b1;
        end else begin
          phase     <= '0;
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (phase == '0) begin
        out   <= '0;
        refx  <= res.px;
        refy  <= res.py;
        sum_x <= '0;
        sum_y <= '0;
      end else begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        if (last) begin
          out.touched <= stable;
          out.pixel_x <= stable ? refx[PIX_X_W-1:0] : '0;
          out.pixel_y <= stable ? refy[PIX_Y_W-1:0] : '0;
        end
      end
    end
  end

  `ASSERT_AT(a_phase_rng, phase <= PHW'(BURST_LENGTH), "burst phase past burst length")
  `ASSERT_AT(a_notouch_zero, out_valid && !out.touched |-> out.pixel_x == '0 && out.pixel_y == '0, "no-touch beat with nonzero pixel")
  `ASSERT_ALWAYS(a_rst_clear, rst |=> phase == '0 && !out_valid, "reset left a burst open")

endmodule
`default_nettype wire

>>> sv/touch_raw_to_pixel_with_stability_unit.sv
// ----------------------------------------------------------------------------
// touch_raw_to_pixel_with_stability_unit
// Maps raw resistive-touch samples to screen pixels and reports one result
// per burst: reference plus BURST_LENGTH samples, or an untouched reference.
// Input: push a sample beat while full is low. Output: a result beat waits
// on result while empty is low and leaves on pop. Corners are written over
// the APB port at 4*i, sign-extended on read, pready tied high.
// A touched sample passes through the mapper as two 30-step serial divides,
// one 30-step and two 14-step serial multiplies and two 9-step scale
// divides at the default sizes; an axis that clamps skips its scale divide.
// An untouched sample goes from the idle state straight to the done state.
// A two-beat queue keeps push open while the mapper is busy; a result beat
// is registered on result after its burst's last sample leaves the mapper.
// If pop stays low the result waits in the output register, the mapper
// holds its next value, the queue fills and full rises.
// Reset returns the corners to their defaults, empties the queue and the
// output, and restarts the burst at the reference sample.
// ----------------------------------------------------------------------------
`default_nettype none
module touch_raw_to_pixel_with_stability_unit import tr2p_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int BURST_LENGTH  = DEF_BURST_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  sample_t           sample,
  input  logic              push,
  output logic              full,
  output result_t           result,
  output logic              empty,
  input  logic              pop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  corners_t cfg;
  reg_idx_t widx;
  logic     cfg_wr;

  logic     q_full, q_push, q_empty, q_pop;
  job_t     q_wdata, q_rdata;
  map_res_t mres;
  logic     mres_valid, mres_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c0x <= 14'sd0;
      cfg.c0y <= 14'sd0;
      cfg.c1x <= 14'sd4095;
      cfg.c1y <= 14'sd0;
      cfg.c2x <= 14'sd4095;
      cfg.c2y <= 14'sd4095;
      cfg.c3x <= 14'sd0;
      cfg.c3y <= 14'sd4095;
    end else if (cfg_wr) begin
      unique case (widx)
        REG_C0X: cfg.c0x <= pwdata[CORNER_W-1:0];
        REG_C0Y: cfg.c0y <= pwdata[CORNER_W-1:0];
        REG_C1X: cfg.c1x <= pwdata[CORNER_W-1:0];
        REG_C1Y: cfg.c1y <= pwdata[CORNER_W-1:0];
        REG_C2X: cfg.c2x <= pwdata[CORNER_W-1:0];
        REG_C2Y: cfg.c2y <= pwdata[CORNER_W-1:0];
        REG_C3X: cfg.c3x <= pwdata[CORNER_W-1:0];
        REG_C3Y: cfg.c3y <= pwdata[CORNER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CORNER_W-1:0] v;
    unique case (widx)
      REG_C0X: v = cfg.c0x;
      REG_C0Y: v = cfg.c0y;
      REG_C1X: v = cfg.c1x;
      REG_C1Y: v = cfg.c1y;
      REG_C2X: v = cfg.c2x;
      REG_C2Y: v = cfg.c2y;
      REG_C3X: v = cfg.c3x;
      REG_C3Y: v = cfg.c3y;
      default: v = '0;
    endcase
    prdata = {{(DATA_W-CORNER_W){v[CORNER_W-1]}}, v};
  end

  tr2p_front u_front (
    .sample  (sample),
    .push    (push),
    .full    (full),
    .corners (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .job     (q_wdata)
  );

  tr2p_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tr2p_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .corners   (cfg),
    .job       (q_rdata),
    .job_valid (!q_empty),
    .job_pop   (q_pop),
    .res       (mres),
    .res_valid (mres_valid),
    .res_ready (mres_ready)
  );

  tr2p_burst #(
    .BURST_LENGTH (BURST_LENGTH)
  ) u_burst (
    .clk       (clk),
    .rst       (rst),
    .res       (mres),
    .res_valid (mres_valid),
    .res_ready (mres_ready),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
